>>> rtl/mlt_pkg.sv
// Shared constants and controller/datapath handshake types for the MAC learning table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none
package mlt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PORT_COUNT    = 16;

  localparam int MAC_W  = 48;
  localparam int PORT_W = 4;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // Wide enough to hold PORT_COUNT itself at the top of its range.
  localparam int PORT_CMP_W = 9;

  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [PORT_CMP_W-1:0] PORT_LIMIT = PORT_CMP_W'(PORT_COUNT);

  localparam logic MODE_SEARCH = 1'b0;
  localparam logic MODE_LEARN  = 1'b1;

  typedef struct packed {
    logic load;    // capture the accepted request beat
    logic issue;   // read the slot under the scan counter
    logic commit;  // update the table and load the response register
  } mlt_cmd_t;

  typedef struct packed {
    logic last_issue;  // scan counter points at the final slot
    logic out_free;    // response register can take a new beat this cycle
  } mlt_sts_t;

endpackage
`default_nettype wire

>>> rtl/mlt_req_if.sv
// Request channel of the MAC learning table: valid/ready plus the request fields.
// Depends on mlt_pkg for field widths.
`default_nettype none
interface mlt_req_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [mlt_pkg::MAC_W-1:0]      mac_address;
  logic [mlt_pkg::PORT_W-1:0]     ingress_port;

  modport source (output valid, output mode, output mac_address, output ingress_port,
                  input ready);
  modport sink   (input valid, input mode, input mac_address, input ingress_port,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/mlt_rsp_if.sv
// Response channel of the MAC learning table: valid/ready plus the result fields.
// Depends on mlt_pkg for field widths.
`default_nettype none
interface mlt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [mlt_pkg::PORT_W-1:0] egress_port;
  logic                       table_full;

  modport source (output valid, output hit, output egress_port, output table_full,
                  input ready);
  modport sink   (input valid, input hit, input egress_port, input table_full,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/mlt_ctrl.sv
// Sequencing state machine of the MAC learning table: accept, scan, drain, commit.
// Depends on mlt_pkg for the command and status structs.
`default_nettype none
module mlt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire mlt_pkg::mlt_sts_t st,
  output mlt_pkg::mlt_cmd_t      cmd
);
  import mlt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (st.last_issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // The final slot read is compared here.
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = st.out_free;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert_scan_then_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> ($past(state) == S_SCAN))
    else $error("drain entered without a scan");

endmodule
`default_nettype wire

>>> rtl/mlt_datapath.sv
// Table storage, scan compare and response register of the MAC learning table.
// Depends on mlt_pkg and mlt_rsp_if; driven by commands from mlt_ctrl.
`default_nettype none
module mlt_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mlt_pkg::mlt_cmd_t           cmd,
  output mlt_pkg::mlt_sts_t                st,
  input  wire logic                        mode,
  input  wire logic [mlt_pkg::MAC_W-1:0]   mac_address,
  input  wire logic [mlt_pkg::PORT_W-1:0]  ingress_port,
  mlt_rsp_if.source                        rsp
);
  import mlt_pkg::*;

  logic [MAC_W-1:0]  addr_mem [TABLE_ENTRIES];
  logic [PORT_W-1:0] port_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_valid;

  logic              item_learn;
  logic [MAC_W-1:0]  item_key;
  logic [PORT_W-1:0] item_port;

  logic [IDX_W-1:0]  cnt;
  logic              q_live;
  logic [IDX_W-1:0]  q_idx;
  logic [MAC_W-1:0]  addr_q;
  logic [PORT_W-1:0] port_q;

  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [PORT_W-1:0] found_port;
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;

  logic              out_valid;
  logic              out_hit;
  logic [PORT_W-1:0] out_port;
  logic              out_full;

  logic              do_learn;
  logic              do_insert;
  logic [IDX_W-1:0]  wr_idx;

  assign st.last_issue = (cnt == LAST_IDX);
  assign st.out_free   = !out_valid || rsp.ready;

  // A learn whose ingress port is out of range leaves the table alone.
  assign do_learn  = (item_learn == MODE_LEARN) &&
                     ({{(PORT_CMP_W-PORT_W){1'b0}}, item_port} < PORT_LIMIT);
  assign do_insert = do_learn && !found && have_free;
  assign wr_idx    = found ? found_idx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_learn <= mode;
      item_key   <= mac_address;
      item_port  <= ingress_port;
    end
  end

  // Slot storage: one read per scan beat, one write at commit.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      addr_q <= addr_mem[cnt];
      port_q <= port_mem[cnt];
      q_idx  <= cnt;
    end
    if (cmd.commit && do_learn && (found || have_free)) begin
      port_mem[wr_idx] <= item_port;
    end
    if (cmd.commit && do_insert) begin
      addr_mem[free_idx] <= item_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      cnt        <= '0;
      q_live     <= 1'b0;
      found      <= 1'b0;
      have_free  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      q_live <= cmd.issue;
      if (cmd.load) begin
        cnt       <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
      end else if (cmd.issue) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (q_live) begin
        // Only valid slots are compared; their key is always written.
        if (slot_valid[q_idx] && addr_q == item_key && !found) begin
          found <= 1'b1;
        end
        if (!slot_valid[q_idx] && !have_free) begin
          have_free <= 1'b1;
        end
      end
      if (cmd.commit && do_insert) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_live && slot_valid[q_idx] && addr_q == item_key && !found) begin
      found_idx  <= q_idx;
      found_port <= port_q;
    end
    if (q_live && !slot_valid[q_idx] && !have_free) begin
      free_idx <= q_idx;
    end
    if (cmd.commit) begin
      out_hit  <= found;
      out_port <= found ? found_port : '0;
      out_full <= do_learn && !found && !have_free;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.egress_port = out_port;
  assign rsp.table_full  = out_full;

  assert_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || rsp.ready))
    else $error("response register overwritten before it was taken");

  assert_found_valid: assert property (@(posedge clk) disable iff (rst)
    found |-> slot_valid[found_idx])
    else $error("matching slot is not valid");

  assert_insert_marks: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_insert) |=> slot_valid[$past(free_idx)])
    else $error("inserted slot not marked valid");

  assert_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_full))
    else $error("hit and table_full raised together");

endmodule
`default_nettype wire

>>> rtl/mac_learning_table_unit.sv
// Top level of the MAC learning table: joins the controller and the datapath.
// Depends on mlt_pkg, mlt_req_if, mlt_rsp_if, mlt_ctrl and mlt_datapath.
//
//   channel  modport  fields                               role
//   req      sink     mode, mac_address, ingress_port      search or learn request
//   rsp      source   hit, egress_port, table_full         one result per request
//
// After its accepting beat, each request reads the single-port slot store one slot per
// cycle, then finishes the last compare in a drain state and commits in a commit state;
// a new request is accepted the cycle after the commit.
// Reset clears all valid bits at once; no clearing pass is run.
// A stalled response holds the commit, and with it the next request, until it is taken.
`default_nettype none
module mac_learning_table_unit (
  input  wire logic clk,
  input  wire logic rst,
  mlt_req_if.sink   req,
  mlt_rsp_if.source rsp
);
  import mlt_pkg::*;

  mlt_cmd_t cmd;
  mlt_sts_t st;
  logic     ready;

  assign req.ready = ready;

  mlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .st        (st),
    .cmd       (cmd)
  );

  mlt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .mode         (req.mode),
    .mac_address  (req.mac_address),
    .ingress_port (req.ingress_port),
    .rsp          (rsp)
  );

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mac_learning_table_unit. A scoreboard class keeps its own
// copy of the forwarding table and checks every response beat against it.
// Depends on mlt_pkg, mlt_req_if, mlt_rsp_if and the RTL of the block.
module tb;
  import mlt_pkg::*;

  localparam int RANDOM_REQUESTS = 1640;
  localparam logic [MAC_W-1:0] MAC_ALL_ONES = {MAC_W{1'b1}};

  typedef struct {
    logic              hit;
    logic [PORT_W-1:0] egress_port;
    logic              table_full;
  } fdb_result_t;

  class fdb_scoreboard;
    bit                slot_used [TABLE_ENTRIES];
    logic [MAC_W-1:0]  slot_mac  [TABLE_ENTRIES];
    logic [PORT_W-1:0] slot_port [TABLE_ENTRIES];
    fdb_result_t       pending_results[$];
    int                errors;
    int                requests;
    int                learns;
    int                hits;
    int                drops;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors   = 0;
      requests = 0;
      learns   = 0;
      hits     = 0;
      drops    = 0;
    endfunction

    // Looks the address up as the table stood before this beat, then applies a learn.
    function void note_request(logic mode, logic [MAC_W-1:0] mac, logic [PORT_W-1:0] port);
      fdb_result_t res;
      int          match_idx;
      int          free_idx;
      res       = '{1'b0, '0, 1'b0};
      match_idx = -1;
      free_idx  = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && slot_mac[i] == mac && match_idx < 0) match_idx = i;
        if (!slot_used[i] && free_idx < 0) free_idx = i;
      end
      if (match_idx >= 0) begin
        res.hit         = 1'b1;
        res.egress_port = slot_port[match_idx];
        hits++;
      end
      if (mode == MODE_LEARN && int'(port) < PORT_COUNT) begin
        learns++;
        if (match_idx >= 0) begin
          slot_port[match_idx] = port;
        end else if (free_idx >= 0) begin
          slot_used[free_idx] = 1'b1;
          slot_mac[free_idx]  = mac;
          slot_port[free_idx] = port;
        end else begin
          res.table_full = 1'b1;
          drops++;
        end
      end
      requests++;
      pending_results.push_back(res);
    endfunction

    function void check_response(logic hit, logic [PORT_W-1:0] egress_port, logic table_full);
      fdb_result_t want;
      if (pending_results.size() == 0) begin
        $error("response beat arrived with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, hit);
        errors++;
      end
      if (egress_port !== want.egress_port) begin
        $error("egress_port: expected %0d, actual %0d", want.egress_port, egress_port);
        errors++;
      end
      if (table_full !== want.table_full) begin
        $error("table_full: expected %0b, actual %0b", want.table_full, table_full);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic [MAC_W-1:0] known_macs[$];
  fdb_scoreboard fdb = new();

  mlt_req_if req();
  mlt_rsp_if rsp();

  mac_learning_table_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  initial rsp.ready = 1'b0;

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      fdb.check_response(rsp.hit, rsp.egress_port, rsp.table_full);
    end
  end

  task automatic send_request(input logic mode, input logic [MAC_W-1:0] mac,
                              input logic [PORT_W-1:0] port);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    // Now and then a long pause, so that a gap also spans a whole table scan.
    if (send_idle_pct > 0 && $urandom_range(0, 7) == 0) begin
      gap += $urandom_range(1, TABLE_ENTRIES + 4);
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.mode         <= mode;
    req.mac_address  <= mac;
    req.ingress_port <= port;
    do @(posedge clk); while (!req.ready);
    fdb.note_request(mode, mac, port);
  endtask

  // Mostly addresses already seen, some fresh ones that fill the table, and some
  // single-bit neighbours of known addresses that must not match.
  task automatic send_random_request();
    logic [MAC_W-1:0] mac;
    logic             mode;
    int               pick;
    pick = $urandom_range(0, 99);
    mode = ($urandom_range(0, 1) == 1) ? MODE_LEARN : MODE_SEARCH;
    if (known_macs.size() == 0 || pick < 16) begin
      mac = MAC_W'({$urandom, $urandom});
      if (mode == MODE_LEARN) known_macs.push_back(mac);
    end else begin
      mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
      if (pick < 24) mac[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
    end
    send_request(mode, mac, PORT_W'($urandom));
  endtask

  initial begin
    req.valid        = 1'b0;
    req.mode         = MODE_SEARCH;
    req.mac_address  = '0;
    req.ingress_port = '0;
    rst              = 1'b1;
    send_idle_pct    = 36;
    recv_idle_pct    = 86;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty table, both address extremes, port extremes and overwrites of known entries.
    send_request(MODE_SEARCH, '0, 4'd7);
    send_request(MODE_LEARN, '0, 4'd0);
    send_request(MODE_LEARN, MAC_ALL_ONES, 4'd15);
    send_request(MODE_SEARCH, '0, 4'd3);
    send_request(MODE_SEARCH, MAC_ALL_ONES, 4'd0);
    send_request(MODE_LEARN, '0, 4'd15);
    send_request(MODE_SEARCH, '0, 4'd0);
    send_request(MODE_LEARN, MAC_ALL_ONES, 4'd0);
    send_request(MODE_SEARCH, MAC_ALL_ONES ^ 48'h1, 4'd15);
    send_request(MODE_SEARCH, 48'h8000_0000_0000, 4'd15);
    send_request(MODE_LEARN, 48'h5555_5555_5555, 4'd10);
    send_request(MODE_SEARCH, 48'hAAAA_AAAA_AAAA, 4'd5);
    send_request(MODE_SEARCH, 48'h5555_5555_5555, 4'd5);
    known_macs.push_back('0);
    known_macs.push_back(MAC_ALL_ONES);
    known_macs.push_back(48'h5555_5555_5555);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 537) begin
        send_idle_pct = 86;
        recv_idle_pct = 36;
      end else if (n == 1087) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_request();
    end
    req.valid <= 1'b0;

    while (fdb.pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 4) @(posedge clk);

    $display("Checked %0d requests: %0d learns, %0d table hits, %0d learns dropped when full.",
             fdb.requests, fdb.learns, fdb.hits, fdb.drops);
    if (fdb.errors == 0 && fdb.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
